// ===== hdl/pl0ts_pkg.sv =====
// Shared types and constants for the PL/0 token scanner.
package pl0ts_pkg;

  // One emitted token.
  typedef struct packed {
    logic [4:0]  kind;
    logic [2:0]  error_code;
    logic [31:0] line_no;
    logic [31:0] start_pos;
    logic [15:0] tok_len;
    logic [62:0] num_value;
    logic        last;
  } res_t;

  // Token kinds
  localparam logic [4:0] K_EOF     = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_NUMBER  = 5'd2;
  localparam logic [4:0] K_STRING  = 5'd3;
  localparam logic [4:0] K_KW_BASE = 5'd4;
  localparam logic [4:0] K_ASSIGN  = 5'd15;
  localparam logic [4:0] K_PERIOD  = 5'd16;
  localparam logic [4:0] K_EQ      = 5'd17;
  localparam logic [4:0] K_COMMA   = 5'd18;
  localparam logic [4:0] K_SEMI    = 5'd19;
  localparam logic [4:0] K_HASH    = 5'd20;
  localparam logic [4:0] K_LT      = 5'd21;
  localparam logic [4:0] K_GT      = 5'd22;
  localparam logic [4:0] K_PLUS    = 5'd23;
  localparam logic [4:0] K_MINUS   = 5'd24;
  localparam logic [4:0] K_STAR    = 5'd25;
  localparam logic [4:0] K_SLASH   = 5'd26;
  localparam logic [4:0] K_LPAREN  = 5'd27;
  localparam logic [4:0] K_RPAREN  = 5'd28;
  localparam logic [4:0] K_ERROR   = 5'd29;

  // Error codes
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_COMMENT  = 3'd1;
  localparam logic [2:0] E_STRING   = 3'd2;
  localparam logic [2:0] E_COLON    = 3'd3;
  localparam logic [2:0] E_UNKNOWN  = 3'd4;
  localparam logic [2:0] E_OVERFLOW = 3'd5;
  localparam logic [2:0] E_DQUOTE   = 3'd6;

  // Keywords, left-justified in 9 bytes: char j sits at [71-8*j -: 8].
  localparam int KW_NUM      = 11;
  localparam int KW_TEXT_MAX = 9;
  localparam logic [71:0] KW_STR [KW_NUM] = '{
    {"const", 32'd0}, {"var", 48'd0}, {"procedure"}, {"call", 40'd0},
    {"begin", 32'd0}, {"end", 48'd0}, {"if", 56'd0}, {"then", 40'd0},
    {"while", 32'd0}, {"do", 56'd0}, {"odd", 48'd0}
  };
  localparam logic [15:0] KW_LEN [KW_NUM] = '{
    16'd5, 16'd3, 16'd9, 16'd4, 16'd5, 16'd3, 16'd2, 16'd4, 16'd5, 16'd2, 16'd3
  };

  localparam logic [62:0] NUM_MAX = '1;

  // Result queue depth; two slots must be free to take a byte.
  localparam int RQ_DEPTH = 4;

endpackage

// ===== hdl/pl0_token_scanner.sv =====
// PL/0 token scanner top level: byte input stage, scan state, result queue.
// A byte is taken into the input stage, scanned once two queue slots are free, and
//   its results are written into the queue, whose head shows on the output.
// Bytes are taken at one per cycle while the queue has room; a byte that yields two
//   tokens gives two queue entries, and input stalls while fewer than two queue slots are free.
// Reset (rst, synchronous): idle mode, line 1, offset 0, queue empty.
module pl0_token_scanner import pl0ts_pkg::*; #(
  parameter int KW_MAX    = 9,
  parameter int LINE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  ch,
  input  logic        ch_valid,
  output logic        ch_stall,
  output logic [4:0]  kind,
  output logic [2:0]  error_code,
  output logic [31:0] line_no,
  output logic [31:0] start_pos,
  output logic [15:0] tok_len,
  output logic [62:0] num_value,
  output logic        last,
  output logic        tok_valid,
  input  logic        tok_stall
);

  localparam int KW_IDX_W = $clog2(KW_MAX);

  // Scan modes
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_IDENT   = 3'd1;
  localparam logic [2:0] M_NUMBER  = 3'd2;
  localparam logic [2:0] M_STRING  = 3'd3;
  localparam logic [2:0] M_COMMENT = 3'd4;
  localparam logic [2:0] M_COLON   = 3'd5;
  localparam logic [2:0] M_HALT    = 3'd6;

  // Input stage
  logic       in_v;
  logic [7:0] in_ch;
  logic       room;
  logic       proc;
  logic       accept;

  // Scan state
  logic [2:0]           mode, mode_next;
  logic [7:0]           kw_buf [KW_MAX];
  logic [7:0]           kw_buf_next [KW_MAX];
  logic [15:0]          ident_length, len_next;
  logic [62:0]          number_acc, acc_next;
  logic [LINE_BITS-1:0] line_count, line_next;
  logic [31:0]          byte_pos, pos_next;
  logic [31:0]          token_start, start_next;

  // Combinational helpers
  logic        c_alpha, c_digit, c_word, c_ws;
  logic        punct_hit;
  logic [4:0]  punct_kind;
  logic [4:0]  kw_kind;
  logic        kw_hit;
  logic [15:0] len_inc;
  logic [66:0] prod;
  logic        ovf;
  logic [31:0] line_sat;

  // Results of one step: p_ = token closed by this byte, i_ = token this byte starts/is
  logic       p_emit, i_emit, do_idle;
  res_t       p_res, i_res;
  logic [1:0] push_n;
  res_t       push0;
  res_t       head;

  // ---------------------------------------------------------------- input stage
  // The held byte is scanned as soon as two queue slots are free; a new byte is
  // taken in the same cycle, so while the queue has room bytes stream through at one per clock.
  assign proc     = in_v && room;
  assign ch_stall = in_v && !room;
  assign accept   = ch_valid && !ch_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (accept) begin
      in_v <= 1'b1;
    end else if (proc) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_ch <= ch;
  end

  // ---------------------------------------------------------------- classifiers
  assign c_alpha = (in_ch >= "a" && in_ch <= "z") || (in_ch >= "A" && in_ch <= "Z");
  assign c_digit = (in_ch >= "0" && in_ch <= "9");
  assign c_word  = c_alpha || c_digit || (in_ch == "_");
  // CR is plain whitespace; only LF counts a line
  assign c_ws    = (in_ch == " ") || (in_ch == 8'h09) || (in_ch == 8'h0D);

  always_comb begin
    punct_hit  = 1'b1;
    punct_kind = K_PERIOD;
    unique case (in_ch)
      ".":     punct_kind = K_PERIOD;
      "=":     punct_kind = K_EQ;
      ",":     punct_kind = K_COMMA;
      ";":     punct_kind = K_SEMI;
      "#":     punct_kind = K_HASH;
      "<":     punct_kind = K_LT;
      ">":     punct_kind = K_GT;
      "+":     punct_kind = K_PLUS;
      "-":     punct_kind = K_MINUS;
      "*":     punct_kind = K_STAR;
      "/":     punct_kind = K_SLASH;
      "(":     punct_kind = K_LPAREN;
      ")":     punct_kind = K_RPAREN;
      default: punct_hit  = 1'b0;
    endcase
  end

  // Keyword lookup: exact length plus the first bytes held in kw_buf.
  always_comb begin
    kw_kind = K_IDENT;
    kw_hit  = 1'b0;
    for (int i = 0; i < KW_NUM; i++) begin
      kw_hit = (ident_length == KW_LEN[i]);
      for (int j = 0; j < KW_TEXT_MAX; j++) begin
        if (16'(j) < KW_LEN[i] && kw_buf[j] != KW_STR[i][71-8*j -: 8]) kw_hit = 1'b0;
      end
      if (kw_hit) kw_kind = K_KW_BASE + 5'(i);
    end
  end

  // acc*10 + digit in 67 bits; anything above 2^63-1 is overflow
  assign prod = {1'b0, number_acc, 3'b000} + {3'b000, number_acc, 1'b0} +
                {63'd0, in_ch[3:0]};
  assign ovf  = (prod[66:63] != 4'd0);

  assign len_inc = (ident_length != 16'hFFFF) ? ident_length + 16'd1 : ident_length;

  generate
    if (LINE_BITS > 32) begin : g_line_wide
      assign line_sat = (|line_count[LINE_BITS-1:32]) ? 32'hFFFF_FFFF : line_count[31:0];
    end else begin : g_line_narrow
      assign line_sat = 32'(line_count);
    end
  endgenerate

  // ---------------------------------------------------------------- scan step
  always_comb begin
    mode_next   = mode;
    kw_buf_next = kw_buf;
    len_next    = ident_length;
    acc_next    = number_acc;
    line_next   = line_count;
    start_next  = token_start;
    pos_next    = (byte_pos != 32'hFFFF_FFFF) ? byte_pos + 32'd1 : byte_pos;
    do_idle     = 1'b0;

    p_emit           = 1'b0;
    p_res            = '0;
    p_res.line_no    = line_sat;
    p_res.start_pos  = token_start;
    p_res.tok_len    = len_inc;
    p_res.kind       = K_ERROR;

    i_emit           = 1'b0;
    i_res            = '0;
    i_res.line_no    = line_sat;
    i_res.start_pos  = byte_pos;
    i_res.last       = 1'b1;

    unique case (mode)
      M_IDENT: begin
        if (c_word) begin
          if (ident_length < 16'(KW_MAX)) kw_buf_next[ident_length[KW_IDX_W-1:0]] = in_ch;
          len_next = len_inc;
        end else begin
          p_emit        = 1'b1;
          p_res.kind    = kw_kind;
          p_res.tok_len = ident_length;
          mode_next     = M_IDLE;
          do_idle       = 1'b1;
        end
      end
      M_NUMBER: begin
        if (c_digit) begin
          if (ovf) begin
            p_emit           = 1'b1;
            p_res.error_code = E_OVERFLOW;
            len_next         = len_inc;
            mode_next        = M_HALT;
          end else begin
            acc_next = prod[62:0];
            len_next = len_inc;
          end
        end else if (in_ch == "_") begin
          len_next = len_inc;
        end else begin
          p_emit          = 1'b1;
          p_res.kind      = K_NUMBER;
          p_res.tok_len   = ident_length;
          p_res.num_value = number_acc;
          acc_next        = '0;
          mode_next       = M_IDLE;
          do_idle         = 1'b1;
        end
      end
      M_STRING: begin
        if (in_ch == 8'h00) begin
          p_emit           = 1'b1;
          p_res.error_code = E_STRING;
          len_next         = len_inc;
          mode_next        = M_HALT;
        end else if (in_ch == "'") begin
          p_emit     = 1'b1;
          p_res.kind = K_STRING;
          len_next   = len_inc;
          mode_next  = M_IDLE;
        end else begin
          if (in_ch == 8'h0A && line_count != '1) line_next = line_count + LINE_BITS'(1);
          len_next = len_inc;
        end
      end
      M_COMMENT: begin
        if (in_ch == 8'h00) begin
          p_emit           = 1'b1;
          p_res.error_code = E_COMMENT;
          len_next         = len_inc;
          mode_next        = M_HALT;
        end else if (in_ch == "}") begin
          mode_next = M_IDLE;
        end else begin
          if (in_ch == 8'h0A && line_count != '1) line_next = line_count + LINE_BITS'(1);
          len_next = len_inc;
        end
      end
      M_COLON: begin
        if (in_ch == "=") begin
          p_emit        = 1'b1;
          p_res.kind    = K_ASSIGN;
          p_res.tok_len = 16'd2;
          mode_next     = M_IDLE;
        end else begin
          p_emit           = 1'b1;
          p_res.error_code = E_COLON;
          len_next         = len_inc;
          mode_next        = M_HALT;
        end
      end
      M_HALT: begin
        pos_next = byte_pos;
      end
      default: begin
        mode_next = M_IDLE;
        do_idle   = 1'b1;
      end
    endcase

    // Byte seen from idle: either it was idle, or it just closed an ident/number.
    if (do_idle) begin
      priority if (c_ws) begin
      end else if (in_ch == 8'h0A) begin
        if (line_count != '1) line_next = line_count + LINE_BITS'(1);
      end else if (c_alpha || in_ch == "_") begin
        mode_next      = M_IDENT;
        start_next     = byte_pos;
        len_next       = 16'd1;
        kw_buf_next[0] = in_ch;
      end else if (c_digit) begin
        mode_next  = M_NUMBER;
        start_next = byte_pos;
        len_next   = 16'd1;
        acc_next   = {59'd0, in_ch[3:0]};
      end else if (in_ch == "'") begin
        mode_next  = M_STRING;
        start_next = byte_pos;
        len_next   = 16'd1;
      end else if (in_ch == "{") begin
        mode_next  = M_COMMENT;
        start_next = byte_pos;
        len_next   = 16'd1;
      end else if (in_ch == ":") begin
        mode_next  = M_COLON;
        start_next = byte_pos;
        len_next   = 16'd1;
      end else if (in_ch == 8'h00) begin
        i_emit     = 1'b1;
        i_res.kind = K_EOF;
        mode_next  = M_HALT;
      end else if (punct_hit) begin
        i_emit        = 1'b1;
        i_res.kind    = punct_kind;
        i_res.tok_len = 16'd1;
      end else begin
        // unknown byte, stray '}' or a double quote
        i_emit           = 1'b1;
        i_res.kind       = K_ERROR;
        i_res.error_code = (in_ch == 8'h22) ? E_DQUOTE : E_UNKNOWN;
        i_res.tok_len    = 16'd1;
        start_next       = byte_pos;
        len_next         = 16'd1;
        mode_next        = M_HALT;
      end
    end

    p_res.last = !i_emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      ident_length <= '0;
      number_acc   <= '0;
      line_count   <= LINE_BITS'(1);
      byte_pos     <= '0;
      token_start  <= '0;
      for (int k = 0; k < KW_MAX; k++) kw_buf[k] <= 8'h00;
    end else if (proc) begin
      mode         <= mode_next;
      ident_length <= len_next;
      number_acc   <= acc_next;
      line_count   <= line_next;
      byte_pos     <= pos_next;
      token_start  <= start_next;
      kw_buf       <= kw_buf_next;
    end
  end

  // ---------------------------------------------------------------- result queue
  assign push_n = proc ? (2'(p_emit) + 2'(i_emit)) : 2'd0;
  assign push0  = p_emit ? p_res : i_res;

  pl0ts_rq u_rq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (push0),
    .push1     (i_res),
    .room      (room),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .head      (head)
  );

  assign kind       = head.kind;
  assign error_code = head.error_code;
  assign line_no    = head.line_no;
  assign start_pos  = head.start_pos;
  assign tok_len    = head.tok_len;
  assign num_value  = head.num_value;
  assign last       = head.last;

  // ---------------------------------------------------------------- assertions
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    mode == M_HALT |-> push_n == 2'd0)
    else $error("scanner emitted a token while halted");

  a_stop_after_end: assert property (@(posedge clk) disable iff (rst)
    proc && ((p_emit && p_res.kind == K_ERROR) ||
             (i_emit && (i_res.kind == K_EOF || i_res.kind == K_ERROR)))
    |=> mode == M_HALT)
    else $error("scanner did not halt after eof or error");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    tok_valid && kind != K_ERROR |-> error_code == E_NONE)
    else $error("error code on a non-error token");

  a_num_clean: assert property (@(posedge clk) disable iff (rst)
    tok_valid && kind != K_NUMBER |-> num_value == 63'd0)
    else $error("value on a non-number token");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != '0)
    else $error("line counter wrapped to zero");

endmodule

// ===== hdl/pl0ts_rq.sv =====
// Small result queue: up to two pushes per cycle, one pop.
module pl0ts_rq import pl0ts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  res_t       push0,
  input  res_t       push1,
  output logic       room,
  output logic       tok_valid,
  input  logic       tok_stall,
  output res_t       head
);

  localparam int AW = $clog2(RQ_DEPTH);
  localparam int CW = $clog2(RQ_DEPTH + 1);

  res_t          ent [RQ_DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [CW-1:0] cnt;
  logic          pop;

  assign tok_valid = (cnt != '0);
  assign pop       = tok_valid && !tok_stall;
  assign room      = (cnt <= CW'(RQ_DEPTH - 2));
  assign head      = ent[rp];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) ent[wp] <= push0;
    if (push_n == 2'd2) ent[wp + AW'(1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + AW'(push_n);
      rp  <= rp + AW'(pop);
      cnt <= cnt + CW'(push_n) - CW'(pop);
    end
  end

endmodule

// ===== tb/sv/tb_pl0_token_scanner.sv =====
// Self-checking bench for pl0_token_scanner: table of PL/0 fragments, random source text, halt.
module tb_pl0_token_scanner import pl0ts_pkg::*; ();

  // random source bytes after the table
  localparam int RAND_BYTES = 1000;
  // keyword compare window, same as the scanner default
  localparam int KW_LIMIT   = 9;
  // filler inside the long string
  localparam int LONG_PAD   = 40;
  // cycles to wait once nothing is outstanding
  localparam int DRAIN_CYC  = 40;
  localparam logic [63:0] VALUE_CAP = {1'b0, NUM_MAX};
  localparam logic [7:0] PUNCT_CH [13] = '{".", "=", ",", ";", "#", "<", ">", "+", "-", "*",
                                           "/", "(", ")"};

  typedef enum logic [2:0] {
    SC_IDLE, SC_IDENT, SC_NUMBER, SC_STRING, SC_COMMENT, SC_COLON, SC_HALT
  } scan_st_t;

  // One fragment of the directed part: head, pad filler bytes, tail.
  // Where checked is set, the final token of the fragment's last byte is typed in.
  typedef struct {
    string       head;
    int          pad;
    string       tail;
    bit          checked;
    logic [4:0]  kind;
    logic [2:0]  err;
    logic [15:0] len;
    logic [62:0] val;
  } frag_t;

  // Typed-in token, tied to the 1-based index of the byte that yields it.
  typedef struct {
    int unsigned at;
    logic [4:0]  kind;
    logic [2:0]  err;
    logic [15:0] len;
    logic [62:0] val;
  } typed_tok_t;

  frag_t frags [21] = '{
    '{"(", 0, "", 1'b1, K_LPAREN, E_NONE, 16'd1, 63'd0},           // first token after reset
    '{".=,;#<>+-*/)", 0, "", 1'b1, K_RPAREN, E_NONE, 16'd1, 63'd0}, // all punctuation but (
    '{" \t\015\n\015\n", 0, "", 1'b0, K_EOF, E_NONE, 16'd0, 63'd0}, // CR LF counts one line
    '{"const var procedure call begin end if then while do odd ", 0, "", 1'b1,
      K_KW_BASE + 5'd10, E_NONE, 16'd3, 63'd0},
    '{"procedures CONST Do x9_ ", 0, "", 1'b1, K_IDENT, E_NONE, 16'd3, 63'd0},
    '{"_ ", 0, "", 1'b1, K_IDENT, E_NONE, 16'd1, 63'd0},
    '{"0 ", 0, "", 1'b1, K_NUMBER, E_NONE, 16'd1, 63'd0},
    '{"9_223_372_036_854_775_807 ", 0, "", 1'b1, K_NUMBER, E_NONE, 16'd25, NUM_MAX},
    '{"12+", 0, "", 1'b1, K_PLUS, E_NONE, 16'd1, 63'd0},
    '{"a:=b;", 0, "", 1'b1, K_SEMI, E_NONE, 16'd1, 63'd0},
    '{"''", 0, "", 1'b1, K_STRING, E_NONE, 16'd2, 63'd0},
    '{"'a''b\n'", 0, "", 1'b1, K_STRING, E_NONE, 16'd4, 63'd0},
    '{"{ note { \n x }{}", 0, "", 1'b0, K_EOF, E_NONE, 16'd0, 63'd0},
    '{"'\200\377\001'", 0, "", 1'b1, K_STRING, E_NONE, 16'd5, 63'd0},
    '{"'", LONG_PAD, "'", 1'b1, K_STRING, E_NONE, 16'(LONG_PAD + 2), 63'd0},
    '{"x\015\n y;", 0, "", 1'b1, K_SEMI, E_NONE, 16'd1, 63'd0},
    '{"begin)", 0, "", 1'b1, K_RPAREN, E_NONE, 16'd1, 63'd0},
    '{"7x_ ", 0, "", 1'b1, K_IDENT, E_NONE, 16'd2, 63'd0},
    '{"var:=", 0, "", 1'b1, K_ASSIGN, E_NONE, 16'd2, 63'd0},
    '{"42_ ", 0, "", 1'b1, K_NUMBER, E_NONE, 16'd3, 63'd42},
    '{"\t{\001\377}", 0, "", 1'b0, K_EOF, E_NONE, 16'd0, 63'd0}
  };

  // DUT ports
  logic        clk = 1'b0;
  logic        rst;
  logic [7:0]  ch;
  logic        ch_valid;
  logic        ch_stall;
  logic [4:0]  kind;
  logic [2:0]  error_code;
  logic [31:0] line_no;
  logic [31:0] start_pos;
  logic [15:0] tok_len;
  logic [62:0] num_value;
  logic        last;
  logic        tok_valid;
  logic        tok_stall;

  // scanner mirror
  scan_st_t    scan_st;
  logic [7:0]  kw_bytes [KW_LIMIT];
  logic [15:0] run_len;
  logic [63:0] acc;
  logic [31:0] line_ct;
  logic [31:0] offset;
  logic [31:0] tok_start;
  res_t        step_out [2];
  int          step_n;

  // scoreboard
  res_t        pending_tokens [$];
  typed_tok_t  typed_tokens [$];
  logic [7:0]  pend [$];
  int unsigned bytes_sent  = 0;
  int unsigned bytes_taken = 0;
  int unsigned tokens_seen = 0;
  int unsigned bad_count   = 0;
  bit          quiet       = 1'b0;

  pl0_token_scanner dut (
    .clk        (clk),
    .rst        (rst),
    .ch         (ch),
    .ch_valid   (ch_valid),
    .ch_stall   (ch_stall),
    .kind       (kind),
    .error_code (error_code),
    .line_no    (line_no),
    .start_pos  (start_pos),
    .tok_len    (tok_len),
    .num_value  (num_value),
    .last       (last),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall)
  );

  always #4 clk = ~clk;

  task automatic note_bad(input string what, input logic [127:0] got, input logic [127:0] want);
    $display("mismatch at token %0d: %s got %0h want %0h", tokens_seen, what, got, want);
    bad_count++;
  endtask

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // --- scanner mirror -------------------------------------------------

  // state right after reset
  task automatic reset_mirror();
    scan_st = SC_IDLE;
    for (int k = 0; k < KW_LIMIT; k++) kw_bytes[k] = 8'h00;
    run_len   = 16'd0;
    acc       = 64'd0;
    line_ct   = 32'd1;
    offset    = 32'd0;
    tok_start = 32'd0;
  endtask

  task automatic add_token(input logic [4:0] k, input logic [2:0] e, input logic [31:0] s,
                           input logic [15:0] l, input logic [63:0] v);
    res_t r;
    r.kind       = k;
    r.error_code = e;
    r.line_no    = line_ct;
    r.start_pos  = s;
    r.tok_len    = l;
    r.num_value  = v[62:0];
    r.last       = 1'b0;
    step_out[step_n] = r;
    step_n++;
  endtask

  task automatic grow_len();
    if (run_len != 16'hFFFF) run_len++;
  endtask

  task automatic next_line();
    if (line_ct != 32'hFFFF_FFFF) line_ct++;
  endtask

  // error token covers the token so far plus the offending byte; then halt
  task automatic raise_error(input logic [2:0] e);
    grow_len();
    add_token(K_ERROR, e, tok_start, run_len, 64'd0);
    scan_st = SC_HALT;
  endtask

  task automatic open_token(input scan_st_t st, input logic [31:0] pos);
    scan_st   = st;
    tok_start = pos;
    run_len   = 16'd1;
  endtask

  // keyword only on exact length match against the buffered prefix
  function automatic logic [4:0] word_kind();
    logic hit;
    for (int i = 0; i < KW_NUM; i++) begin
      if (run_len == KW_LEN[i] && KW_LEN[i] <= KW_LIMIT) begin
        hit = 1'b1;
        for (int j = 0; j < KW_LEN[i]; j++)
          if (kw_bytes[j] != KW_STR[i][71-8*j -: 8]) hit = 1'b0;
        if (hit) return K_KW_BASE + 5'(i);
      end
    end
    return K_IDENT;
  endfunction

  task automatic start_from_idle(input logic [7:0] c, input logic [31:0] pos);
    if (c == " " || c == "\t" || c == "\015") return;
    if (c == "\n") begin
      next_line();
      return;
    end
    if (is_letter(c) || c == "_") begin
      open_token(SC_IDENT, pos);
      kw_bytes[0] = c;
      return;
    end
    if (is_digit(c)) begin
      open_token(SC_NUMBER, pos);
      acc = 64'(c - 8'd48);
      return;
    end
    if (c == "'") begin
      open_token(SC_STRING, pos);
      return;
    end
    if (c == "{") begin
      open_token(SC_COMMENT, pos);
      return;
    end
    if (c == ":") begin
      open_token(SC_COLON, pos);
      return;
    end
    if (c == 8'h00) begin
      add_token(K_EOF, E_NONE, pos, 16'd0, 64'd0);
      scan_st = SC_HALT;
      return;
    end
    for (int i = 0; i < 13; i++) begin
      if (c == PUNCT_CH[i]) begin
        add_token(K_PERIOD + 5'(i), E_NONE, pos, 16'd1, 64'd0);
        return;
      end
    end
    // unknown byte, stray close brace or double quote
    tok_start = pos;
    run_len   = 16'd0;
    raise_error(c == "\"" ? E_DQUOTE : E_UNKNOWN);
  endtask

  // Advance the mirror by one accepted byte and queue the tokens it yields.
  task automatic tokenize_byte(input logic [7:0] c);
    logic [31:0] pos;
    logic [63:0] d;
    bit          back_idle;
    typed_tok_t  hc;
    pos       = offset;
    back_idle = 1'b0;
    step_n    = 0;
    bytes_taken++;
    if (scan_st != SC_HALT) begin
      case (scan_st)
        SC_IDENT: begin
          if (is_letter(c) || is_digit(c) || c == "_") begin
            if (run_len < KW_LIMIT) kw_bytes[run_len] = c;
            grow_len();
          end else begin
            add_token(word_kind(), E_NONE, tok_start, run_len, 64'd0);
            back_idle = 1'b1;
          end
        end
        SC_NUMBER: begin
          if (is_digit(c)) begin
            d = 64'(c - 8'd48);
            if (acc > (VALUE_CAP - d) / 10) begin
              raise_error(E_OVERFLOW);
            end else begin
              acc = acc * 10 + d;
              grow_len();
            end
          end else if (c == "_") begin
            grow_len();
          end else begin
            add_token(K_NUMBER, E_NONE, tok_start, run_len, acc);
            acc       = 64'd0;
            back_idle = 1'b1;
          end
        end
        SC_STRING: begin
          if (c == 8'h00) begin
            raise_error(E_STRING);
          end else if (c == "'") begin
            grow_len();
            add_token(K_STRING, E_NONE, tok_start, run_len, 64'd0);
            scan_st = SC_IDLE;
          end else begin
            if (c == "\n") next_line();
            grow_len();
          end
        end
        SC_COMMENT: begin
          if (c == 8'h00) begin
            raise_error(E_COMMENT);
          end else if (c == "}") begin
            scan_st = SC_IDLE;
          end else begin
            if (c == "\n") next_line();
            grow_len();
          end
        end
        SC_COLON: begin
          if (c == "=") begin
            add_token(K_ASSIGN, E_NONE, tok_start, 16'd2, 64'd0);
            scan_st = SC_IDLE;
          end else begin
            raise_error(E_COLON);
          end
        end
        default: back_idle = 1'b1;
      endcase
      // the byte that closed an ident or number is scanned again from idle
      if (back_idle) begin
        scan_st = SC_IDLE;
        start_from_idle(c, pos);
      end
      if (offset != 32'hFFFF_FFFF) offset++;
    end
    if (step_n > 0) step_out[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) pending_tokens.push_back(step_out[i]);
    // typed-in rows: compare with the final token of this byte
    if (typed_tokens.size() != 0 && typed_tokens[0].at == bytes_taken) begin
      hc = typed_tokens.pop_front();
      if (step_n == 0)
        note_bad("typed row produced no token", 128'd0,
                 128'({hc.kind, hc.err, hc.len, hc.val}));
      else if ({step_out[step_n-1].kind, step_out[step_n-1].error_code,
                step_out[step_n-1].tok_len, step_out[step_n-1].num_value} !==
               {hc.kind, hc.err, hc.len, hc.val})
        note_bad("typed row {kind,err,len,val}",
                 128'({step_out[step_n-1].kind, step_out[step_n-1].error_code,
                       step_out[step_n-1].tok_len, step_out[step_n-1].num_value}),
                 128'({hc.kind, hc.err, hc.len, hc.val}));
    end
  endtask

  // --- output side ----------------------------------------------------

  task automatic check_token();
    res_t want;
    if (pending_tokens.size() == 0) begin
      note_bad("token with nothing outstanding, kind", 128'(kind), 128'd0);
      return;
    end
    want = pending_tokens.pop_front();
    if (kind !== want.kind) note_bad("kind", 128'(kind), 128'(want.kind));
    if (error_code !== want.error_code)
      note_bad("error_code", 128'(error_code), 128'(want.error_code));
    if (line_no !== want.line_no) note_bad("line_no", 128'(line_no), 128'(want.line_no));
    if (start_pos !== want.start_pos)
      note_bad("start_pos", 128'(start_pos), 128'(want.start_pos));
    if (tok_len !== want.tok_len) note_bad("tok_len", 128'(tok_len), 128'(want.tok_len));
    if (num_value !== want.num_value)
      note_bad("num_value", 128'(num_value), 128'(want.num_value));
    if (last !== want.last) note_bad("last", 128'(last), 128'(want.last));
    tokens_seen++;
  endtask

  // Sample both handshakes at the rising edge; stimulus moves on the falling edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (ch_valid && !ch_stall) tokenize_byte(ch);
      if (tok_valid && !tok_stall) check_token();
    end
  end

  // Consumer: random stall bursts, none once quiet.
  initial begin
    tok_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        tok_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        tok_stall <= 1'b0;
      end
    end
  end

  // --- producer -------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after the request
  // was taken, with valid still high so back-to-back requests need no gap.
  task automatic put_char(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      ch_valid <= 1'b0;
      ch       <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    ch       <= b;
    ch_valid <= 1'b1;
    do @(posedge clk); while (ch_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) pend.push_back(s[i]);
  endtask

  // typed token due on the last byte currently queued
  task automatic note_typed(input logic [4:0] k, input logic [2:0] e, input logic [15:0] l,
                            input logic [62:0] v);
    typed_tokens.push_back('{bytes_sent + pend.size(), k, e, l, v});
  endtask

  task automatic send_pending();
    while (pend.size() != 0) put_char(pend.pop_front());
  endtask

  // One well-formed lexeme (or blank run) with random content.
  // A number never directly follows a number, so no overflow happens here.
  task automatic send_lexeme(inout bit last_num);
    int          pick;
    int          n;
    int          kw;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (last_num && pick >= 25 && pick < 45) pend.push_back(" ");
    last_num = 1'b0;
    if (pick < 25) begin
      if ($urandom_range(0, 4) == 0) begin
        kw = $urandom_range(0, KW_NUM - 1);
        for (int j = 0; j < KW_LEN[kw]; j++) pend.push_back(KW_STR[kw][71-8*j -: 8]);
      end else begin
        n = $urandom_range(1, 12);
        pend.push_back($urandom_range(0, 1) ? 8'($urandom_range(97, 122))
                                            : 8'($urandom_range(65, 90)));
        for (int j = 1; j < n; j++) begin
          case ($urandom_range(0, 3))
            0:       pend.push_back(8'($urandom_range(48, 57)));
            1:       pend.push_back("_");
            2:       pend.push_back(8'($urandom_range(65, 90)));
            default: pend.push_back(8'($urandom_range(97, 122)));
          endcase
        end
      end
    end else if (pick < 45) begin
      if ($urandom_range(0, 19) == 0) begin
        queue_text("9223372036854775807");
      end else begin
        n = $urandom_range(1, 18);
        for (int j = 0; j < n; j++) begin
          pend.push_back(8'($urandom_range(48, 57)));
          if ($urandom_range(0, 5) == 0) pend.push_back("_");
        end
      end
      last_num = 1'b1;
    end else if (pick < 60) begin
      pend.push_back(PUNCT_CH[$urandom_range(0, 12)]);
    end else if (pick < 65) begin
      queue_text(":=");
    end else if (pick < 75) begin
      pend.push_back("'");
      repeat ($urandom_range(0, 10)) begin
        do b = 8'($urandom_range(1, 255)); while (b == "'");
        pend.push_back(b);
      end
      pend.push_back("'");
    end else if (pick < 82) begin
      pend.push_back("{");
      repeat ($urandom_range(0, 12)) begin
        do b = 8'($urandom_range(1, 255)); while (b == "}");
        pend.push_back($urandom_range(0, 5) == 0 ? 8'h0A : b);
      end
      pend.push_back("}");
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 4))
          0:       pend.push_back("\t");
          1:       pend.push_back("\n");
          2:       queue_text("\015\n");
          default: pend.push_back(" ");
        endcase
      end
    end
    send_pending();
  endtask

  // --- main sequence --------------------------------------------------

  initial begin
    int unsigned rand_base;
    bit          last_num;
    logic [7:0]  b;
    string       end_note;
    rst      = 1'b1;
    ch       = 8'h00;
    ch_valid = 1'b0;
    last_num = 1'b0;
    reset_mirror();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed fragments
    foreach (frags[r]) begin
      queue_text(frags[r].head);
      repeat (frags[r].pad) pend.push_back("z");
      queue_text(frags[r].tail);
      if (frags[r].checked) note_typed(frags[r].kind, frags[r].err, frags[r].len, frags[r].val);
      send_pending();
    end

    // hold off until the scanner has drained everything
    ch_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    // random source text; last fifth runs with no idling on either side
    rand_base = bytes_sent;
    while (bytes_sent - rand_base < RAND_BYTES) begin
      quiet = (bytes_sent - rand_base) > RAND_BYTES * 4 / 5;
      send_lexeme(last_num);
    end

    // one terminating event per run; the seed picks which
    case ($urandom_range(0, 8))
      0: begin
        end_note = "end of input";
        pend.push_back(8'h00);
        note_typed(K_EOF, E_NONE, 16'd0, 63'd0);
      end
      1: begin
        end_note = "identifier cut by end of input";
        queue_text(" ab");
        pend.push_back(8'h00);
        note_typed(K_EOF, E_NONE, 16'd0, 63'd0);
      end
      2: begin
        end_note = "number cut by end of input";
        queue_text(" 42");
        pend.push_back(8'h00);
        note_typed(K_EOF, E_NONE, 16'd0, 63'd0);
      end
      3: begin
        end_note = "open comment";
        queue_text("{ x");
        pend.push_back(8'h00);
        note_typed(K_ERROR, E_COMMENT, 16'd4, 63'd0);
      end
      4: begin
        end_note = "open string";
        queue_text("'ab");
        pend.push_back(8'h00);
        note_typed(K_ERROR, E_STRING, 16'd4, 63'd0);
      end
      5: begin
        end_note = "colon without equals";
        do b = 8'($urandom_range(0, 255)); while (b == "=");
        pend.push_back(":");
        pend.push_back(b);
        note_typed(K_ERROR, E_COLON, 16'd2, 63'd0);
      end
      6: begin
        end_note = "unknown byte";
        if ($urandom_range(0, 1)) queue_text(" ab");
        case ($urandom_range(0, 2))
          0:       pend.push_back(8'($urandom_range(128, 255)));
          1:       pend.push_back("}");
          default: pend.push_back("?");
        endcase
        note_typed(K_ERROR, E_UNKNOWN, 16'd1, 63'd0);
      end
      7: begin
        end_note = "number overflow";
        queue_text(" 9223372036854775808");
        note_typed(K_ERROR, E_OVERFLOW, 16'd19, 63'd0);
      end
      default: begin
        end_note = "double quote";
        queue_text(" \"");
        note_typed(K_ERROR, E_DQUOTE, 16'd1, 63'd0);
      end
    endcase
    send_pending();

    // halted: further bytes must give nothing
    repeat (16) pend.push_back(8'($urandom_range(0, 255)));
    send_pending();
    ch_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("scanned %0d bytes (%0d random) and checked %0d tokens, %0d typed rows left",
             bytes_sent, bytes_sent - rand_base, tokens_seen, typed_tokens.size());
    $display("run ended on %s, %0d mismatches", end_note, bad_count);
    if (bad_count == 0 && typed_tokens.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout: scanner stopped making progress");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pl0ts_pkg.sv
hdl/pl0ts_rq.sv
hdl/pl0_token_scanner.sv
tb/sv/tb_pl0_token_scanner.sv
